// ----- src/bpq_pkg.sv -----
package bpq_pkg;

	localparam int LIMIT_W = 5;
	localparam int OCC_W   = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic [1:0] ACT_ENQ    = 2'd0;
	localparam logic [1:0] ACT_DEQ    = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;
	localparam logic [1:0] ACT_FLUSH  = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  priority_req;
		logic [31:0] key;
		logic [31:0] payload;
	} req_t;

	typedef struct packed {
		logic             item_valid;
		logic [7:0]       out_priority;
		logic [31:0]      out_key;
		logic [31:0]      out_payload;
		logic             inserted;
		logic             drop_happened;
		logic [OCC_W-1:0] removed_count;
		logic [OCC_W-1:0] occupancy;
		logic [31:0]      total_enqueued;
		logic [31:0]      total_dequeued;
		logic [31:0]      total_dropped;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [31:0] key;
		logic [31:0] payload;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     push;
	} cell_ctl_t;

endpackage

// ----- src/bpq_cell.sv -----
module bpq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic             clk,
	input  bpq_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]    cnt,
	input  logic [CW-1:0]    pos,
	input  bpq_pkg::entry_t  ins_entry,
	input  bpq_pkg::entry_t  head_entry,
	input  bpq_pkg::entry_t  prev_entry,
	input  bpq_pkg::entry_t  next_entry,
	input  logic             prev_gt,
	output bpq_pkg::entry_t  entry,
	output logic             gt
);
	import bpq_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	entry_t entry_q;

	// chain is sorted by priority, high first, older first among equals
	assign gt    = (MY_IDX >= cnt) || (ins_entry.prio > entry_q.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (gt && !prev_gt) begin
					entry_q <= ins_entry;
				end else if (gt) begin
					entry_q <= prev_entry;
				end
			end
			CELL_SHIFT: begin
				if (ctl.push && (pos == MY_IDX)) begin
					entry_q <= head_entry;
				end else begin
					entry_q <= next_entry;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/bounded_priority_queue_evict_lowest.sv -----
// Channel   Signals                      Dir  Handshake
// config    cfg_we, cfg_wdata            in   write on cfg_we, no wait
// request   req_valid, req_ready, req    in   taken on valid & ready
// response  rsp_valid, rsp_ready, rsp    out  taken on valid & ready
//
// Enqueue below the limit, rejected enqueue, dequeue and flush go straight to done.
// Enqueue with eviction rotates the chain, then inserts; cancel rotates (unless empty).
// Eviction and cancel rotate the cell chain through cell 0, one entry a cycle.
// Reset: queue empty, counters zero, limit 16; no clearing pass.
// One response register; a new request is taken while it waits, and the next
// response holds in the done state until the register frees.
module bounded_priority_queue_evict_lowest #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpq_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bpq_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bpq_pkg::rsp_t                 rsp
);
	import bpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROT,
		S_INS,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                rsp_valid_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       rot_q;
	logic                evd_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [31:0]         enq_cnt_q;
	logic [31:0]         deq_cnt_q;
	logic [31:0]         drop_cnt_q;

	req_t                req_q;
	logic [7:0]          tail_q;
	logic [7:0]          last_q;
	logic                res_valid_q;
	entry_t              res_entry_q;
	logic                res_ins_q;
	logic                res_drop_q;
	logic [CW-1:0]       rm_q;
	rsp_t                rsp_q;

	entry_t              ent [CAPACITY];
	logic [CAPACITY-1:0] gt_v;
	entry_t              head;
	entry_t              in_e;
	entry_t              req_e;
	entry_t              ins_e;
	cell_ctl_t           ctl;
	logic [CW-1:0]       pos;

	logic                accept;
	logic                out_free;
	logic                full;
	logic                rot_keep;
	logic                rot_last;
	logic [EW-1:0]       lim0;
	logic [EW-1:0]       eff_lim;
	logic [7:0]          new_tail;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign head  = ent[0];
	assign in_e  = '{prio: req.priority_req, key: req.key, payload: req.payload};
	assign req_e = '{prio: req_q.priority_req, key: req_q.key, payload: req_q.payload};

	assign lim0    = (limit_q == '0) ? EW'(1) : EW'(limit_q);
	assign eff_lim = (lim0 > EW'(CAPACITY)) ? EW'(CAPACITY) : lim0;
	assign full    = (EW'(cnt_q) >= eff_lim);

	assign rot_keep = (req_q.action == ACT_CANCEL) ? (head.key != req_q.key)
		: !(!evd_q && (head.prio == tail_q));
	assign rot_last = (rot_q == CW'(1));

	assign new_tail = ((cnt_q == '0) || (ins_e.prio < tail_q)) ? ins_e.prio : tail_q;

	always_comb begin
		ctl   = '{op: CELL_HOLD, push: 1'b0};
		ins_e = in_e;
		pos   = cnt_q - CW'(1);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_ENQ: begin
							if (!full) begin
								ctl.op = CELL_INSERT;
							end
						end
						ACT_DEQ: begin
							if (cnt_q != '0) begin
								ctl.op = CELL_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_ROT: begin
				ctl.op   = CELL_SHIFT;
				ctl.push = rot_keep;
			end
			S_INS: begin
				ctl.op = CELL_INSERT;
				ins_e  = req_e;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_gt;
		if (i == 0) begin : g_first
			assign prev_e  = ins_e;
			assign prev_gt = 1'b0;
		end else begin : g_mid
			assign prev_e  = ent[i-1];
			assign prev_gt = gt_v[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_e = ent[i];
		end else begin : g_inner
			assign next_e = ent[i+1];
		end
		bpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cnt        (cnt_q),
			.pos        (pos),
			.ins_entry  (ins_e),
			.head_entry (head),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.prev_gt    (prev_gt),
			.entry      (ent[i]),
			.gt         (gt_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
			rot_q       <= '0;
			evd_q       <= 1'b0;
			limit_q     <= LIMIT_RESET;
			enq_cnt_q   <= '0;
			deq_cnt_q   <= '0;
			drop_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						evd_q <= 1'b0;
						case (req.action)
							ACT_ENQ: begin
								if (!full) begin
									cnt_q     <= cnt_q + CW'(1);
									enq_cnt_q <= enq_cnt_q + 32'd1;
									state_q   <= S_DONE;
								end else begin
									drop_cnt_q <= drop_cnt_q + 32'd1;
									if (req.priority_req >= tail_q) begin
										rot_q   <= cnt_q;
										state_q <= S_ROT;
									end else begin
										state_q <= S_DONE;
									end
								end
							end
							ACT_DEQ: begin
								state_q <= S_DONE;
								if (cnt_q != '0) begin
									cnt_q     <= cnt_q - CW'(1);
									deq_cnt_q <= deq_cnt_q + 32'd1;
								end
							end
							ACT_CANCEL: begin
								if (cnt_q != '0) begin
									rot_q   <= cnt_q;
									state_q <= S_ROT;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q    <= S_DONE;
								cnt_q      <= '0;
								enq_cnt_q  <= '0;
								deq_cnt_q  <= '0;
								drop_cnt_q <= '0;
							end
						endcase
					end
				end
				S_ROT: begin
					rot_q <= rot_q - CW'(1);
					if (!rot_keep) begin
						cnt_q <= cnt_q - CW'(1);
						evd_q <= 1'b1;
					end
					if (rot_last) begin
						state_q <= (req_q.action == ACT_CANCEL) ? S_DONE : S_INS;
					end
				end
				S_INS: begin
					cnt_q     <= cnt_q + CW'(1);
					enq_cnt_q <= enq_cnt_q + 32'd1;
					state_q   <= S_DONE;
				end
				default: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == CELL_INSERT) begin
			tail_q <= new_tail;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q       <= req;
					res_valid_q <= (req.action == ACT_DEQ) && (cnt_q != '0);
					res_entry_q <= ((req.action == ACT_DEQ) && (cnt_q != '0)) ? head
						: entry_t'('0);
					res_ins_q   <= (req.action == ACT_ENQ) && !full;
					res_drop_q  <= (req.action == ACT_ENQ) && full;
					rm_q        <= '0;
				end
			end
			S_ROT: begin
				if (rot_keep) begin
					last_q <= head.prio;
				end else if (req_q.action == ACT_CANCEL) begin
					rm_q <= rm_q + CW'(1);
				end
				if (rot_last) begin
					tail_q <= rot_keep ? head.prio : last_q;
				end
			end
			S_INS: begin
				res_ins_q <= 1'b1;
			end
			default: begin
				if (out_free) begin
					rsp_q <= '{
						item_valid:     res_valid_q,
						out_priority:   res_entry_q.prio,
						out_key:        res_entry_q.key,
						out_payload:    res_entry_q.payload,
						inserted:       res_ins_q,
						drop_happened:  res_drop_q,
						removed_count:  OCC_W'(rm_q),
						occupancy:      OCC_W'(cnt_q),
						total_enqueued: enq_cnt_q,
						total_dequeued: deq_cnt_q,
						total_dropped:  drop_cnt_q
					};
				end
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.action == ACT_FLUSH) |=> cnt_q == '0)
		else $error("flush left entries");

	a_rot_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROT |=> cnt_q <= $past(cnt_q))
		else $error("rotation grew the queue");

	a_rot_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) && rot_last |=> (state_q == S_INS) || (state_q == S_DONE))
		else $error("rotation did not end on its last step");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> cnt_q < CW'(CAPACITY))
		else $error("insert into a full chain");

endmodule

// ----- dv/bpq_queue_checker.sv -----
module bpq_queue_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bpq_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                        req_valid,
	input  logic                        req_ready,
	input  bpq_pkg::req_t               req,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  bpq_pkg::rsp_t               rsp,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bpq_pkg::*;

	entry_t             held[$];
	rsp_t               predicted_rsp[$];
	logic [LIMIT_W-1:0] limit_reg;
	logic [31:0]        enq_total;
	logic [31:0]        deq_total;
	logic [31:0]        drop_total;

	// queue held oldest first; ties resolve to the oldest entry
	task automatic predict_queue_step(input req_t r, output rsp_t e);
		int     lim;
		int     pick;
		int     removed;
		bit     store;
		entry_t fresh;
		entry_t kept[$];
		e = '0;
		case (r.action)
			ACT_ENQ: begin
				lim = (limit_reg == 0) ? 1 :
					((limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg));
				store = 1'b1;
				if (held.size() >= lim && held.size() > 0) begin
					pick = 0;
					for (int i = 1; i < held.size(); i++)
						if (held[i].prio < held[pick].prio)
							pick = i;
					e.drop_happened = 1'b1;
					drop_total++;
					if (r.priority_req >= held[pick].prio)
						held.delete(pick);
					else
						store = 1'b0;
				end
				if (store && held.size() < CAPACITY) begin
					fresh.prio    = r.priority_req;
					fresh.key     = r.key;
					fresh.payload = r.payload;
					held.insert(held.size(), fresh);
					enq_total++;
					e.inserted = 1'b1;
				end
			end
			ACT_DEQ: begin
				if (held.size() > 0) begin
					pick = 0;
					for (int i = 1; i < held.size(); i++)
						if (held[i].prio > held[pick].prio)
							pick = i;
					e.item_valid   = 1'b1;
					e.out_priority = held[pick].prio;
					e.out_key      = held[pick].key;
					e.out_payload  = held[pick].payload;
					held.delete(pick);
					deq_total++;
				end
			end
			ACT_CANCEL: begin
				removed = 0;
				foreach (held[i]) begin
					if (held[i].key == r.key)
						removed++;
					else
						kept.insert(kept.size(), held[i]);
				end
				held = kept;
				e.removed_count = OCC_W'(removed);
			end
			default: begin
				held.delete();
				enq_total  = '0;
				deq_total  = '0;
				drop_total = '0;
			end
		endcase
		e.occupancy      = OCC_W'(held.size());
		e.total_enqueued = enq_total;
		e.total_dequeued = deq_total;
		e.total_dropped  = drop_total;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("%0t %s mismatch: expected %h, got %h", $realtime, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			held.delete();
			predicted_rsp.delete();
			limit_reg   = LIMIT_RESET;
			enq_total   = '0;
			deq_total   = '0;
			drop_total  = '0;
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				limit_reg = cfg_wdata;
			if (req_valid && req_ready) begin
				predict_queue_step(req, e);
				predicted_rsp.insert(predicted_rsp.size(), e);
			end
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp.size() == 0) begin
					if (mismatches < 10)
						$display("%0t response with no request pending: %h", $realtime, rsp);
					mismatches++;
				end else begin
					e = predicted_rsp.pop_front();
					check_field("item_valid", e.item_valid, rsp.item_valid);
					check_field("out_priority", e.out_priority, rsp.out_priority);
					check_field("out_key", e.out_key, rsp.out_key);
					check_field("out_payload", e.out_payload, rsp.out_payload);
					check_field("inserted", e.inserted, rsp.inserted);
					check_field("drop_happened", e.drop_happened, rsp.drop_happened);
					check_field("removed_count", e.removed_count, rsp.removed_count);
					check_field("occupancy", e.occupancy, rsp.occupancy);
					check_field("total_enqueued", e.total_enqueued, rsp.total_enqueued);
					check_field("total_dequeued", e.total_dequeued, rsp.total_dequeued);
					check_field("total_dropped", e.total_dropped, rsp.total_dropped);
				end
			end
			outstanding = predicted_rsp.size();
		end
	end

endmodule

// ----- dv/bounded_priority_queue_evict_lowest_tb.sv -----
module bounded_priority_queue_evict_lowest_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpq_pkg::*;

	localparam int CAPACITY       = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_REQUESTS = 79;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	logic               req_valid = 1'b0;
	req_t               req       = '0;
	logic               rsp_ready = 1'b0;
	logic               req_ready;
	logic               rsp_valid;
	rsp_t               rsp;

	int                 mismatches;
	int                 outstanding;
	int                 stalled_cycles = 0;
	int                 gap_pct        = 0;
	int                 stall_pct      = 0;
	logic [31:0]        key_pool[4];
	logic [LIMIT_W-1:0] phase_limit[PHASES];

	always #4 clk = ~clk;

	bounded_priority_queue_evict_lowest #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_wdata,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	bpq_queue_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_wdata,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp,
		.mismatches,
		.outstanding
	);

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// called and returns at a falling edge; valid stays high for back-to-back requests
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_queue();
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		drain_queue();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t make_req(input logic [1:0] act, input logic [7:0] prio,
			input logic [31:0] key, input logic [31:0] payload);
		req_t r;
		r.action       = act;
		r.priority_req = prio;
		r.key          = key;
		r.payload      = payload;
		return r;
	endfunction

	// small key pool so cancels hit; coarse priorities so ties are common
	function automatic req_t random_request(input int enq_pct);
		int   roll;
		req_t r;
		roll = $urandom_range(99);
		if (roll < enq_pct)
			r.action = ACT_ENQ;
		else if (roll < enq_pct + (97 - enq_pct) * 2 / 3)
			r.action = ACT_DEQ;
		else if (roll < 97)
			r.action = ACT_CANCEL;
		else
			r.action = ACT_FLUSH;
		r.priority_req = $urandom_range(1) ? 8'($urandom_range(3) * 85)
			: 8'($urandom_range(255));
		r.key     = ($urandom_range(99) < 60) ? key_pool[$urandom_range(3)] : $urandom();
		r.payload = $urandom();
		return r;
	endfunction

	initial begin
		int p;
		int i;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = $urandom();
		key_pool[3] = $urandom();
		phase_limit[0] = 5'd16;
		phase_limit[1] = 5'd1;
		phase_limit[2] = 5'd0;
		phase_limit[3] = 5'd31;
		phase_limit[4] = 5'd4;
		phase_limit[5] = 5'd8;
		phase_limit[6] = 5'd2;
		phase_limit[7] = 5'd12;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(make_req(ACT_DEQ, 8'd0, 32'd0, 32'd0));
		send_request(make_req(ACT_CANCEL, 8'd0, 32'd5, 32'd0));
		send_request(make_req(ACT_ENQ, 8'd0, 32'h0000_0000, 32'h0000_0000));
		send_request(make_req(ACT_ENQ, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_request(make_req(ACT_ENQ, 8'd255, 32'd1, 32'd2));
		send_request(make_req(ACT_DEQ, 8'd0, 32'd0, 32'd0));
		send_request(make_req(ACT_CANCEL, 8'd0, 32'h0000_0000, 32'd0));

		write_limit(5'd3);
		send_request(make_req(ACT_ENQ, 8'd7, 32'd9, 32'hA5A5_0001));
		send_request(make_req(ACT_ENQ, 8'd7, 32'd9, 32'hA5A5_0002));
		// full: lower priority is rejected, equal priority evicts the oldest lowest
		send_request(make_req(ACT_ENQ, 8'd6, 32'd3, 32'hA5A5_0003));
		send_request(make_req(ACT_ENQ, 8'd7, 32'd4, 32'hA5A5_0004));
		send_request(make_req(ACT_CANCEL, 8'd0, 32'd9, 32'd0));
		send_request(make_req(ACT_ENQ, 8'd200, 32'd9, 32'h5A5A_0005));
		send_request(make_req(ACT_ENQ, 8'd9, 32'd9, 32'h5A5A_0006));
		send_request(make_req(ACT_CANCEL, 8'd0, 32'd9, 32'd0));
		send_request(make_req(ACT_DEQ, 8'd0, 32'd0, 32'd0));
		send_request(make_req(ACT_DEQ, 8'd0, 32'd0, 32'd0));
		send_request(make_req(ACT_FLUSH, 8'd0, 32'd0, 32'd0));
		send_request(make_req(ACT_DEQ, 8'd0, 32'd0, 32'd0));
		send_request(make_req(ACT_ENQ, 8'd128, 32'h8000_0000, 32'h7FFF_FFFF));

		for (p = 0; p < PHASES; p++) begin
			write_limit(phase_limit[p]);
			case (p % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 70;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 70;
				end
				default: begin
					gap_pct   = 34;
					stall_pct = 34;
				end
			endcase
			for (i = 0; i < PHASE_REQUESTS; i++) begin
				if (i == PHASE_REQUESTS / 2)
					drain_queue();
				send_request(random_request((phase_limit[p] > 8) ? 65 : 50));
			end
		end

		gap_pct   = 0;
		stall_pct = 0;
		drain_queue();
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
